### rtl/core/gql_pkg.sv
package gql_pkg;

   // Fixed field widths
   localparam int COEF_BITS     = 16;
   localparam int REWARD_BITS   = 16;
   localparam int DRAW_BITS     = 16;
   localparam int POS_BITS      = 4;
   localparam int STEP_BITS     = 8;
   localparam int EPISODE_BITS  = 16;
   localparam int OUT_Q_BITS    = 16;
   localparam int ACT_BITS      = 2;
   localparam int NUM_ACTIONS   = 4;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   // Action codes
   localparam logic [ACT_BITS-1:0] ACT_LEFT  = 2'd0;
   localparam logic [ACT_BITS-1:0] ACT_RIGHT = 2'd1;
   localparam logic [ACT_BITS-1:0] ACT_UP    = 2'd2;
   localparam logic [ACT_BITS-1:0] ACT_DOWN  = 2'd3;

   // Register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LEARN_RATE    = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DISCOUNT      = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_EXPLORE_THR   = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_GOAL_REWARD   = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_STEP_PENALTY  = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_STEP_LIMIT    = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_EPISODE_COUNT = 3'd6;

   // Register reset values
   localparam logic [COEF_BITS-1:0]           RST_LEARN_RATE    = 16'd6554;
   localparam logic [COEF_BITS-1:0]           RST_DISCOUNT      = 16'd58982;
   localparam logic [DRAW_BITS-1:0]           RST_EXPLORE_THR   = 16'd6554;
   localparam logic signed [REWARD_BITS-1:0]  RST_GOAL_REWARD   = 16'sd4096;
   localparam logic signed [REWARD_BITS-1:0]  RST_STEP_PENALTY  = -16'sd410;
   localparam logic [STEP_BITS-1:0]           RST_STEP_LIMIT    = 8'd100;
   localparam logic [EPISODE_BITS-1:0]        RST_EPISODE_COUNT = 16'd10000;

   typedef struct packed {
      logic [DRAW_BITS-1:0] explore_draw;
      logic [ACT_BITS-1:0]  random_move;
   } req_type;

   typedef struct packed {
      logic [ACT_BITS-1:0]           action_taken;
      logic                          explored;
      logic [POS_BITS-1:0]           new_row;
      logic [POS_BITS-1:0]           new_col;
      logic signed [REWARD_BITS-1:0] step_reward;
      logic signed [OUT_Q_BITS-1:0]  updated_value;
      logic                          episode_end;
      logic                          training_done;
   } rsp_type;

endpackage

### rtl/core/gql_mulrnd.sv
// Shared multiplier: unsigned Q0.16 coefficient times signed operand,
// rounded by adding one half and dropping the 16 fraction bits.
module gql_mulrnd #(
   parameter int OP_BITS = 19
) (
   input  logic                          clock,
   input  logic [gql_pkg::COEF_BITS-1:0] coef,
   input  logic signed [OP_BITS-1:0]     operand,
   output logic signed [OP_BITS:0]       result
);

   localparam int PW = OP_BITS + gql_pkg::COEF_BITS + 1;

   logic signed [PW-1:0] coef_ext;
   logic signed [PW-1:0] op_ext;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] rounded;
   logic signed [PW-gql_pkg::COEF_BITS-1:0] result_ff;

   // Extend both factors to the full product width
   assign coef_ext = PW'({1'b0, coef});
   assign op_ext   = PW'(operand);
   assign prod     = coef_ext * op_ext;
   assign rounded  = prod + (PW'(1) <<< (gql_pkg::COEF_BITS - 1));

   // Register the rounded product
   always_ff @(posedge clock) begin
      result_ff <= rounded[PW-1:gql_pkg::COEF_BITS];
   end

   assign result = result_ff;

endmodule

### rtl/core/gridworld_q_learning_step.sv
// Tabular Q-learning agent for a GRID_DIM x GRID_DIM grid, one agent step per item.
// Request channel (req_valid/req_ready/req_data) carries the exploration draw and
// the random move; the response channel (rsp_valid/rsp_ready/rsp_data) returns one
// item per request: action, position after the move, reward and the new Q value.
// The csr_ port writes the seven training registers; write only while idle.
// A training step runs ST_SCAN_CUR, ST_MOVE, ST_SCAN_NXT, ST_MUL_G, ST_TGT, ST_MUL_A,
// ST_UPD and ST_OUT; a step taken once training is finished goes from ST_IDLE straight
// to ST_OUT. The block holds one item at a time; a step takes two argmax scans over the
// four actions through one shared comparator, the table row reads, and two passes
// through the single shared multiplier for the discount and learning-rate products.
// The Q table is one memory row per cell (four actions), with a valid bit per cell
// so that an unwritten cell reads as zero; no clearing pass is needed.
// Reset: synchronous, clears position, step and episode counters, the cell valid
// bits and loads the register defaults.
// Stall: a finished response waits in the output register; the sequencer holds in
// its last step until the register is free, and req_ready stays low meanwhile.
module gridworld_q_learning_step #(
   parameter int GRID_DIM   = 4,
   parameter int VALUE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  gql_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output gql_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [gql_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  logic [gql_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int CW    = $clog2(GRID_DIM);
   localparam int CELLS = GRID_DIM * GRID_DIM;
   localparam int AW    = $clog2(CELLS);
   localparam int QW    = VALUE_BITS;
   localparam int WIDE  = (VALUE_BITS > gql_pkg::REWARD_BITS) ? VALUE_BITS
                                                              : gql_pkg::REWARD_BITS;
   localparam int MW    = WIDE + 3;
   localparam int RW    = MW + 2;
   localparam int NA    = gql_pkg::NUM_ACTIONS;
   localparam int LW    = NA * QW;
   localparam logic [CW-1:0] EDGE_POS = CW'(GRID_DIM - 1);
   localparam logic [1:0]    LAST_ACT = 2'(NA - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_CUR,
      ST_MOVE,
      ST_SCAN_NXT,
      ST_MUL_G,
      ST_TGT,
      ST_MUL_A,
      ST_UPD,
      ST_OUT
   } state_type;

   // Registers and next values
   state_type                                state_ff, state_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                            agent_row_ff, agent_row_in;
   logic [CW-1:0]                            agent_col_ff, agent_col_in;
   logic [gql_pkg::STEP_BITS-1:0]            episode_steps_ff, episode_steps_in;
   logic [gql_pkg::EPISODE_BITS-1:0]         episodes_done_ff, episodes_done_in;
   logic [CELLS-1:0]                         cell_valid_ff;
   logic                                     rd_valid_ff;
   logic [LW-1:0]                            rd_row_ff;

   logic                                     explore_ff, explore_in;
   logic [1:0]                               move_ff, move_in;
   logic [1:0]                               scan_idx_ff, scan_idx_in;
   logic [1:0]                               best_idx_ff, best_idx_in;
   logic signed [QW-1:0]                     best_val_ff, best_val_in;
   logic [1:0]                               act_ff, act_in;
   logic [CW-1:0]                            nr_ff, nr_in;
   logic [CW-1:0]                            nc_ff, nc_in;
   logic                                     goal_ff, goal_in;
   logic signed [gql_pkg::REWARD_BITS-1:0]   reward_ff, reward_in;
   logic signed [QW-1:0]                     q_old_ff, q_old_in;
   logic [LW-1:0]                            cur_row_ff, cur_row_in;
   logic signed [MW-1:0]                     base_ff, base_in;
   logic signed [MW-1:0]                     diff_ff, diff_in;
   gql_pkg::rsp_type                         res_ff, res_in;
   gql_pkg::rsp_type                         rsp_ff, rsp_in;

   // Configuration registers
   logic [gql_pkg::COEF_BITS-1:0]            learn_rate_ff;
   logic [gql_pkg::COEF_BITS-1:0]            discount_ff;
   logic [gql_pkg::DRAW_BITS-1:0]            explore_thr_ff;
   logic signed [gql_pkg::REWARD_BITS-1:0]   goal_reward_ff;
   logic signed [gql_pkg::REWARD_BITS-1:0]   step_penalty_ff;
   logic [gql_pkg::STEP_BITS-1:0]            step_limit_ff;
   logic [gql_pkg::EPISODE_BITS-1:0]         episode_count_ff;

   // Datapath wires
   logic                                     req_take;
   logic                                     train_done;
   logic [AW-1:0]                            cur_cell;
   logic [AW-1:0]                            nxt_cell;
   logic [AW-1:0]                            rd_addr;
   logic                                     mem_re;
   logic                                     mem_we;
   logic [LW-1:0]                            rd_row;
   logic [LW-1:0]                            wr_row;
   logic signed [QW-1:0]                     cand;
   logic                                     take;
   logic                                     scan_last;
   logic [1:0]                               act_sel;
   logic [CW-1:0]                            mv_row;
   logic [CW-1:0]                            mv_col;
   logic                                     mv_goal;
   logic [gql_pkg::COEF_BITS-1:0]            mul_coef;
   logic signed [MW-1:0]                     mul_op;
   logic signed [MW:0]                       mul_res;
   logic signed [RW-1:0]                     upd_sum;
   logic signed [QW-1:0]                     new_q;
   logic [gql_pkg::STEP_BITS-1:0]            steps_next;
   logic                                     ep_end;

   // Q table: one row of four action values per cell
   logic [LW-1:0]                            mem [CELLS];

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_take   = req_valid && req_ready;
   assign train_done = (episodes_done_ff >= episode_count_ff);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign cur_cell = AW'(agent_row_ff) * AW'(GRID_DIM) + AW'(agent_col_ff);
   assign nxt_cell = AW'(mv_row) * AW'(GRID_DIM) + AW'(mv_col);
   assign rd_addr  = (state_ff == ST_MOVE) ? nxt_cell : cur_cell;
   assign mem_re   = (req_take && !train_done) || (state_ff == ST_MOVE);
   assign mem_we   = (state_ff == ST_UPD);

   // Unwritten cells read as zero
   assign rd_row = rd_valid_ff ? rd_row_ff : '0;

   // Shared comparator for both argmax scans
   assign cand      = rd_row[scan_idx_ff*QW +: QW];
   assign take      = (scan_idx_ff == 2'd0) || (cand > best_val_ff);
   assign scan_last = (scan_idx_ff == LAST_ACT);

   // Move one cell with clamping at the edges
   assign act_sel = explore_ff ? move_ff : best_idx_ff;

   always_comb begin
      mv_row = agent_row_ff;
      mv_col = agent_col_ff;
      case (act_sel)
         gql_pkg::ACT_LEFT:  if (agent_col_ff != '0) mv_col = agent_col_ff - 1'b1;
         gql_pkg::ACT_RIGHT: if (agent_col_ff != EDGE_POS) mv_col = agent_col_ff + 1'b1;
         gql_pkg::ACT_UP:    if (agent_row_ff != '0) mv_row = agent_row_ff - 1'b1;
         gql_pkg::ACT_DOWN:  if (agent_row_ff != EDGE_POS) mv_row = agent_row_ff + 1'b1;
         default: ;
      endcase
   end

   assign mv_goal = (mv_row == EDGE_POS) && (mv_col == EDGE_POS);

   // Feed the shared multiplier: discount pass, then learning-rate pass
   assign mul_coef = (state_ff == ST_MUL_A) ? learn_rate_ff : discount_ff;
   assign mul_op   = (state_ff == ST_MUL_A) ? diff_ff : MW'(best_val_ff);

   gql_mulrnd #(
      .OP_BITS (MW)
   ) u_mulrnd (
      .clock   (clock),
      .coef    (mul_coef),
      .operand (mul_op),
      .result  (mul_res)
   );

   // Saturate the updated value to the table width
   assign upd_sum = RW'(q_old_ff) + RW'(mul_res);

   always_comb begin
      if (upd_sum[RW-1:QW-1] == '0 || upd_sum[RW-1:QW-1] == '1) begin
         new_q = upd_sum[QW-1:0];
      end else if (upd_sum[RW-1]) begin
         new_q = {1'b1, {(QW-1){1'b0}}};
      end else begin
         new_q = {1'b0, {(QW-1){1'b1}}};
      end
   end

   // Merge the new value into the saved row
   always_comb begin
      wr_row = cur_row_ff;
      for (int a = 0; a < NA; a++) begin
         if (act_ff == 2'(a)) begin
            wr_row[a*QW +: QW] = new_q;
         end
      end
   end

   assign steps_next = episode_steps_ff + 1'b1;
   assign ep_end     = goal_ff || (steps_next >= step_limit_ff);

   // Sequencer next-state and datapath next values
   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      agent_row_in     = agent_row_ff;
      agent_col_in     = agent_col_ff;
      episode_steps_in = episode_steps_ff;
      episodes_done_in = episodes_done_ff;
      explore_in       = explore_ff;
      move_in          = move_ff;
      scan_idx_in      = scan_idx_ff;
      best_idx_in      = best_idx_ff;
      best_val_in      = best_val_ff;
      act_in           = act_ff;
      nr_in            = nr_ff;
      nc_in            = nc_ff;
      goal_in          = goal_ff;
      reward_in        = reward_ff;
      q_old_in         = q_old_ff;
      cur_row_in       = cur_row_ff;
      base_in          = base_ff;
      diff_in          = diff_ff;
      res_in           = res_ff;
      rsp_in           = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               explore_in  = (req_data.explore_draw < explore_thr_ff);
               move_in     = req_data.random_move;
               scan_idx_in = 2'd0;
               if (train_done) begin
                  res_in               = '0;
                  res_in.new_row       = gql_pkg::POS_BITS'(agent_row_ff);
                  res_in.new_col       = gql_pkg::POS_BITS'(agent_col_ff);
                  res_in.training_done = 1'b1;
                  state_in             = ST_OUT;
               end else begin
                  state_in = ST_SCAN_CUR;
               end
            end
         end

         // Find the first best action of the current cell
         ST_SCAN_CUR: begin
            if (take) begin
               best_val_in = cand;
               best_idx_in = scan_idx_ff;
            end
            scan_idx_in = scan_idx_ff + 1'b1;
            if (scan_last) begin
               state_in = ST_MOVE;
            end
         end

         // Commit the action, save the row, read the next cell
         ST_MOVE: begin
            act_in      = act_sel;
            nr_in       = mv_row;
            nc_in       = mv_col;
            goal_in     = mv_goal;
            reward_in   = mv_goal ? goal_reward_ff : step_penalty_ff;
            q_old_in    = rd_row[act_sel*QW +: QW];
            cur_row_in  = rd_row;
            scan_idx_in = 2'd0;
            state_in    = ST_SCAN_NXT;
         end

         // Find the best value of the next cell
         ST_SCAN_NXT: begin
            if (take) begin
               best_val_in = cand;
               best_idx_in = scan_idx_ff;
            end
            base_in     = MW'(reward_ff) - MW'(q_old_ff);
            scan_idx_in = scan_idx_ff + 1'b1;
            if (scan_last) begin
               state_in = ST_MUL_G;
            end
         end

         ST_MUL_G: begin
            state_in = ST_TGT;
         end

         // Form r + gamma*maxQ' - Q
         ST_TGT: begin
            diff_in  = MW'(RW'(base_ff) + RW'(mul_res));
            state_in = ST_MUL_A;
         end

         ST_MUL_A: begin
            state_in = ST_UPD;
         end

         // Write back, advance the agent and build the result item
         ST_UPD: begin
            res_in.action_taken  = act_ff;
            res_in.explored      = explore_ff;
            res_in.new_row       = gql_pkg::POS_BITS'(nr_ff);
            res_in.new_col       = gql_pkg::POS_BITS'(nc_ff);
            res_in.step_reward   = reward_ff;
            res_in.updated_value = gql_pkg::OUT_Q_BITS'(new_q);
            res_in.episode_end   = ep_end;
            res_in.training_done = 1'b0;
            if (ep_end) begin
               agent_row_in     = '0;
               agent_col_in     = '0;
               episode_steps_in = '0;
               episodes_done_in = episodes_done_ff + 1'b1;
            end else begin
               agent_row_in     = nr_ff;
               agent_col_in     = nc_ff;
               episode_steps_in = steps_next;
            end
            state_in = ST_OUT;
         end

         // Hold until the output register is free
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         agent_row_ff     <= '0;
         agent_col_ff     <= '0;
         episode_steps_ff <= '0;
         episodes_done_ff <= '0;
         cell_valid_ff    <= '0;
         rd_valid_ff      <= 1'b0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         agent_row_ff     <= agent_row_in;
         agent_col_ff     <= agent_col_in;
         episode_steps_ff <= episode_steps_in;
         episodes_done_ff <= episodes_done_in;
         if (mem_re) begin
            rd_valid_ff <= cell_valid_ff[rd_addr];
         end
         if (mem_we) begin
            cell_valid_ff[cur_cell] <= 1'b1;
         end
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      explore_ff  <= explore_in;
      move_ff     <= move_in;
      scan_idx_ff <= scan_idx_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      act_ff      <= act_in;
      nr_ff       <= nr_in;
      nc_ff       <= nc_in;
      goal_ff     <= goal_in;
      reward_ff   <= reward_in;
      q_old_ff    <= q_old_in;
      cur_row_ff  <= cur_row_in;
      base_ff     <= base_in;
      diff_ff     <= diff_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   // Q table memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cur_cell] <= wr_row;
      end
      if (mem_re) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff    <= gql_pkg::RST_LEARN_RATE;
         discount_ff      <= gql_pkg::RST_DISCOUNT;
         explore_thr_ff   <= gql_pkg::RST_EXPLORE_THR;
         goal_reward_ff   <= gql_pkg::RST_GOAL_REWARD;
         step_penalty_ff  <= gql_pkg::RST_STEP_PENALTY;
         step_limit_ff    <= gql_pkg::RST_STEP_LIMIT;
         episode_count_ff <= gql_pkg::RST_EPISODE_COUNT;
      end else if (csr_we) begin
         unique case (csr_addr)
            gql_pkg::CSR_LEARN_RATE:    learn_rate_ff    <= csr_wdata;
            gql_pkg::CSR_DISCOUNT:      discount_ff      <= csr_wdata;
            gql_pkg::CSR_EXPLORE_THR:   explore_thr_ff   <= csr_wdata;
            gql_pkg::CSR_GOAL_REWARD:   goal_reward_ff   <= csr_wdata;
            gql_pkg::CSR_STEP_PENALTY:  step_penalty_ff  <= csr_wdata;
            gql_pkg::CSR_STEP_LIMIT:    step_limit_ff    <= csr_wdata[gql_pkg::STEP_BITS-1:0];
            gql_pkg::CSR_EPISODE_COUNT: episode_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

### rtl/core/gql_check.sv
module gql_check #(
   parameter int GRID_DIM = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  gql_pkg::rsp_type rsp_data
);

   localparam logic [gql_pkg::POS_BITS-1:0] EDGE_POS = gql_pkg::POS_BITS'(GRID_DIM - 1);

   // A stalled response item stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response item dropped while stalled");

   // A stalled response item keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // One item at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a step is in progress");

   // A finished-training step reports no update
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.training_done |->
         rsp_data.updated_value == '0 && rsp_data.step_reward == '0 &&
         !rsp_data.episode_end && !rsp_data.explored && rsp_data.action_taken == '0)
      else $error("finished-training item carries an update");

   // Reaching the goal cell always ends the episode
   a_goal_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.training_done &&
      rsp_data.new_row == EDGE_POS && rsp_data.new_col == EDGE_POS |->
         rsp_data.episode_end)
      else $error("goal reached without episode end");

endmodule

bind gridworld_q_learning_step gql_check #(
   .GRID_DIM (GRID_DIM)
) u_gql_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### bench/gridworld_q_learning_step_tb.sv
`timescale 1ns / 1ps

module gridworld_q_learning_step_tb;

   localparam int GRID_DIM      = 4;
   localparam int TABLE_DEPTH   = GRID_DIM * GRID_DIM * gql_pkg::NUM_ACTIONS;
   localparam longint Q_HIGH    = 32767;
   localparam longint Q_LOW     = -32768;
   localparam int TOTAL_ITEMS   = 1450;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 20;
   localparam logic [gql_pkg::CSR_ADDR_BITS-1:0] CSR_UNUSED_INDEX = 3'd7;

   typedef struct {
      bit                                is_csr;
      logic [gql_pkg::CSR_ADDR_BITS-1:0] addr;
      logic [gql_pkg::CSR_DATA_BITS-1:0] wdata;
      gql_pkg::req_type                  item;
      bit                                typed;
      gql_pkg::rsp_type                  want;
   } plan_row_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   gql_pkg::req_type                  req_data;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   gql_pkg::rsp_type                  rsp_data;
   logic                              csr_we;
   logic [gql_pkg::CSR_ADDR_BITS-1:0] csr_addr;
   logic [gql_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   // Agent model: training registers
   logic [gql_pkg::COEF_BITS-1:0]          alpha_q16;
   logic [gql_pkg::COEF_BITS-1:0]          gamma_q16;
   logic [gql_pkg::DRAW_BITS-1:0]          epsilon_thr;
   logic signed [gql_pkg::REWARD_BITS-1:0] goal_r;
   logic signed [gql_pkg::REWARD_BITS-1:0] move_penalty;
   logic [gql_pkg::STEP_BITS-1:0]          limit_steps;
   logic [gql_pkg::EPISODE_BITS-1:0]       episodes_target;

   // Agent model: learned state
   longint                                 q_value [TABLE_DEPTH];
   logic [gql_pkg::POS_BITS-1:0]           agent_row;
   logic [gql_pkg::POS_BITS-1:0]           agent_col;
   logic [gql_pkg::STEP_BITS-1:0]          steps_taken;
   logic [gql_pkg::EPISODE_BITS-1:0]       episodes_done;

   gql_pkg::rsp_type pending_results[$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      sent_items  = 0;
   int      stall_left  = 0;
   bit      steady      = 1'b0;

   gridworld_q_learning_step #(
      .GRID_DIM   (GRID_DIM),
      .VALUE_BITS (16)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int idle_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Lowest numbered action with the largest value in the cell
   function automatic int best_move(int base);
      int best;
      best = 0;
      for (int a = 1; a < gql_pkg::NUM_ACTIONS; a++) begin
         if (q_value[base + a] > q_value[base + best]) best = a;
      end
      return best;
   endfunction

   // Add half, then floor-shift by 16
   function automatic longint round_q16(longint v);
      return (v + 64'sd32768) >>> 16;
   endfunction

   function automatic void apply_reg(logic [gql_pkg::CSR_ADDR_BITS-1:0] addr,
                                     logic [gql_pkg::CSR_DATA_BITS-1:0] data);
      case (addr)
         gql_pkg::CSR_LEARN_RATE:    alpha_q16       = data;
         gql_pkg::CSR_DISCOUNT:      gamma_q16       = data;
         gql_pkg::CSR_EXPLORE_THR:   epsilon_thr     = data;
         gql_pkg::CSR_GOAL_REWARD:   goal_r          = data;
         gql_pkg::CSR_STEP_PENALTY:  move_penalty    = data;
         gql_pkg::CSR_STEP_LIMIT:    limit_steps     = data[gql_pkg::STEP_BITS-1:0];
         gql_pkg::CSR_EPISODE_COUNT: episodes_target = data;
         default: ;
      endcase
   endfunction

   // One agent step: choose, move, reward, update the table, advance the episode
   function automatic gql_pkg::rsp_type predict_agent_step(gql_pkg::req_type item);
      gql_pkg::rsp_type                res;
      int                              base;
      int                              nbase;
      int                              idx;
      logic [gql_pkg::ACT_BITS-1:0]    act;
      logic [gql_pkg::POS_BITS-1:0]    nr;
      logic [gql_pkg::POS_BITS-1:0]    nc;
      longint                          reward;
      longint                          target;
      longint                          newq;
      logic                            at_goal;
      logic                            ends;
      res = '0;
      if (episodes_done >= episodes_target) begin
         res.new_row       = agent_row;
         res.new_col       = agent_col;
         res.training_done = 1'b1;
         return res;
      end
      base = (int'(agent_row) * GRID_DIM + int'(agent_col)) * gql_pkg::NUM_ACTIONS;
      if (item.explore_draw < epsilon_thr) begin
         act          = item.random_move;
         res.explored = 1'b1;
      end else begin
         act = 2'(best_move(base));
      end
      // Move one cell, clamp at the edges
      nr = agent_row;
      nc = agent_col;
      case (act)
         gql_pkg::ACT_LEFT:  if (nc > 0) nc = nc - 1'b1;
         gql_pkg::ACT_RIGHT: if (nc < GRID_DIM - 1) nc = nc + 1'b1;
         gql_pkg::ACT_UP:    if (nr > 0) nr = nr - 1'b1;
         gql_pkg::ACT_DOWN:  if (nr < GRID_DIM - 1) nr = nr + 1'b1;
         default: ;
      endcase
      at_goal = (nr == GRID_DIM - 1) && (nc == GRID_DIM - 1);
      reward  = at_goal ? longint'(goal_r) : longint'(move_penalty);
      // Q(s,a) += alpha * (r + gamma * maxQ(s') - Q(s,a)), saturated
      nbase  = (int'(nr) * GRID_DIM + int'(nc)) * gql_pkg::NUM_ACTIONS;
      idx    = base + int'(act);
      target = reward + round_q16(longint'(gamma_q16) * q_value[nbase + best_move(nbase)]);
      newq   = q_value[idx] + round_q16(longint'(alpha_q16) * (target - q_value[idx]));
      if (newq > Q_HIGH) newq = Q_HIGH;
      else if (newq < Q_LOW) newq = Q_LOW;
      q_value[idx] = newq;
      steps_taken  = steps_taken + 1'b1;
      ends         = at_goal || (steps_taken >= limit_steps);
      res.action_taken  = act;
      res.new_row       = nr;
      res.new_col       = nc;
      res.step_reward   = reward[gql_pkg::REWARD_BITS-1:0];
      res.updated_value = newq[gql_pkg::OUT_Q_BITS-1:0];
      res.episode_end   = ends;
      // Restart at the corner once the episode is over
      if (ends) begin
         agent_row     = '0;
         agent_col     = '0;
         steps_taken   = '0;
         episodes_done = episodes_done + 1'b1;
      end else begin
         agent_row = nr;
         agent_col = nc;
      end
      return res;
   endfunction

   function automatic plan_row_type csr_row(logic [gql_pkg::CSR_ADDR_BITS-1:0] addr,
                                            logic [gql_pkg::CSR_DATA_BITS-1:0] data);
      plan_row_type r;
      r        = '{default: '0};
      r.is_csr = 1'b1;
      r.addr   = addr;
      r.wdata  = data;
      return r;
   endfunction

   function automatic plan_row_type step_row(logic [gql_pkg::DRAW_BITS-1:0] draw,
                                             logic [gql_pkg::ACT_BITS-1:0] move);
      plan_row_type r;
      r                   = '{default: '0};
      r.item.explore_draw = draw;
      r.item.random_move  = move;
      return r;
   endfunction

   // Step after training is over, taken from the corner: nothing moves
   function automatic plan_row_type done_row(logic [gql_pkg::DRAW_BITS-1:0] draw,
                                             logic [gql_pkg::ACT_BITS-1:0] move);
      plan_row_type r;
      r                    = step_row(draw, move);
      r.typed              = 1'b1;
      r.want.training_done = 1'b1;
      return r;
   endfunction

   function automatic logic [15:0] pick_word(logic [15:0] typical);
      case ($urandom_range(0, 6))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h7FFF;
         3:       return 16'h8000;
         4:       return typical;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic write_reg(logic [gql_pkg::CSR_ADDR_BITS-1:0] addr,
                            logic [gql_pkg::CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_reg(addr, data);
      @(posedge clock);
   endtask

   // Drop valid and hold until every pending result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_item(gql_pkg::req_type item, bit typed, gql_pkg::rsp_type want);
      gql_pkg::rsp_type predicted;
      int               gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predicted = predict_agent_step(item);
      sent_items++;
      pending_results.push_back(typed ? want : predicted);
   endtask

   // New training setup between phases, extremes favored
   task automatic pick_training_setup();
      logic [15:0] v;
      if ($urandom_range(0, 3) != 0)
         write_reg(gql_pkg::CSR_LEARN_RATE, pick_word(gql_pkg::RST_LEARN_RATE));
      if ($urandom_range(0, 3) != 0)
         write_reg(gql_pkg::CSR_DISCOUNT, pick_word(gql_pkg::RST_DISCOUNT));
      if ($urandom_range(0, 3) != 0)
         write_reg(gql_pkg::CSR_EXPLORE_THR, pick_word(gql_pkg::RST_EXPLORE_THR));
      if ($urandom_range(0, 3) != 0)
         write_reg(gql_pkg::CSR_GOAL_REWARD, pick_word(gql_pkg::RST_GOAL_REWARD));
      if ($urandom_range(0, 3) != 0)
         write_reg(gql_pkg::CSR_STEP_PENALTY, pick_word(gql_pkg::RST_STEP_PENALTY));
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 9))
            0:       v = 16'd0;
            1:       v = 16'd1;
            2:       v = 16'd255;
            3:       v = 16'($urandom_range(13, 254));
            default: v = 16'($urandom_range(2, 12));
         endcase
         write_reg(gql_pkg::CSR_STEP_LIMIT, v);
      end
      case ($urandom_range(0, 9))
         0:       write_reg(gql_pkg::CSR_EPISODE_COUNT, 16'd0);
         1:       write_reg(gql_pkg::CSR_EPISODE_COUNT,
                            episodes_done + 16'($urandom_range(0, 3)));
         2:       write_reg(gql_pkg::CSR_EPISODE_COUNT, 16'($urandom_range(0, 65535)));
         default: write_reg(gql_pkg::CSR_EPISODE_COUNT, 16'hFFFF);
      endcase
      if ($urandom_range(0, 7) == 0)
         write_reg(CSR_UNUSED_INDEX, 16'($urandom_range(0, 65535)));
   endtask

   task automatic report_field(string name, longint want, longint got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic check_result(gql_pkg::rsp_type got, gql_pkg::rsp_type want);
      report_field("action_taken", want.action_taken, got.action_taken);
      report_field("explored", want.explored, got.explored);
      report_field("new_row", want.new_row, got.new_row);
      report_field("new_col", want.new_col, got.new_col);
      report_field("step_reward", want.step_reward, got.step_reward);
      report_field("updated_value", want.updated_value, got.updated_value);
      report_field("episode_end", want.episode_end, got.episode_end);
      report_field("training_done", want.training_done, got.training_done);
   endtask

   // Result side: check each accepted item, stall at random
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: result with no step pending, expected none, actual %h",
                     $time, rsp_data);
         end else begin
            check_result(rsp_data, pending_results.pop_front());
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         stall_left <= idle_gap();
         rsp_ready  <= (stall_left == 0) && ($urandom_range(0, 1) == 1 || steady);
      end
   end

   always @(posedge clock) begin
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      plan_row_type     plan[$];
      gql_pkg::req_type item;
      int               phase_len;

      // Model after reset
      alpha_q16       = gql_pkg::RST_LEARN_RATE;
      gamma_q16       = gql_pkg::RST_DISCOUNT;
      epsilon_thr     = gql_pkg::RST_EXPLORE_THR;
      goal_r          = gql_pkg::RST_GOAL_REWARD;
      move_penalty    = gql_pkg::RST_STEP_PENALTY;
      limit_steps     = gql_pkg::RST_STEP_LIMIT;
      episodes_target = gql_pkg::RST_EPISODE_COUNT;
      foreach (q_value[i]) q_value[i] = 0;
      agent_row     = '0;
      agent_col     = '0;
      steps_taken   = '0;
      episodes_done = '0;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_addr  = '0;
      csr_wdata = '0;

      // Training over from the start: steps change nothing
      plan.push_back(csr_row(gql_pkg::CSR_EPISODE_COUNT, 16'd0));
      plan.push_back(done_row(16'h0000, gql_pkg::ACT_DOWN));
      plan.push_back(done_row(16'hFFFF, gql_pkg::ACT_UP));
      // Zero step limit: every step ends the episode
      plan.push_back(csr_row(gql_pkg::CSR_EPISODE_COUNT, 16'hFFFF));
      plan.push_back(csr_row(gql_pkg::CSR_STEP_LIMIT, 16'd0));
      plan.push_back(step_row(16'h0000, gql_pkg::ACT_RIGHT));
      plan.push_back(step_row(16'hFFFF, gql_pkg::ACT_LEFT));
      // Walk the edges into the goal with forced moves, ending with a greedy step
      plan.push_back(csr_row(gql_pkg::CSR_STEP_LIMIT, 16'd255));
      plan.push_back(csr_row(gql_pkg::CSR_EXPLORE_THR, 16'hFFFF));
      plan.push_back(step_row(16'h0000, gql_pkg::ACT_LEFT));
      plan.push_back(step_row(16'h0001, gql_pkg::ACT_UP));
      plan.push_back(step_row(16'hAAAA, gql_pkg::ACT_DOWN));
      plan.push_back(step_row(16'h5555, gql_pkg::ACT_DOWN));
      plan.push_back(step_row(16'h00FF, gql_pkg::ACT_DOWN));
      plan.push_back(step_row(16'hFF00, gql_pkg::ACT_DOWN));
      plan.push_back(step_row(16'h1234, gql_pkg::ACT_RIGHT));
      plan.push_back(step_row(16'hFFFE, gql_pkg::ACT_RIGHT));
      plan.push_back(step_row(16'h8000, gql_pkg::ACT_RIGHT));
      plan.push_back(step_row(16'h7FFF, gql_pkg::ACT_RIGHT));
      plan.push_back(step_row(16'h0F0F, gql_pkg::ACT_RIGHT));
      plan.push_back(step_row(16'hF0F0, gql_pkg::ACT_RIGHT));
      plan.push_back(step_row(16'h3C3C, gql_pkg::ACT_RIGHT));
      plan.push_back(step_row(16'hFFFF, gql_pkg::ACT_LEFT));
      // Extreme rates and rewards drive the values into saturation
      plan.push_back(csr_row(gql_pkg::CSR_GOAL_REWARD, 16'h7FFF));
      plan.push_back(csr_row(gql_pkg::CSR_STEP_PENALTY, 16'h8000));
      plan.push_back(csr_row(gql_pkg::CSR_LEARN_RATE, 16'hFFFF));
      plan.push_back(csr_row(gql_pkg::CSR_DISCOUNT, 16'hFFFF));
      plan.push_back(csr_row(CSR_UNUSED_INDEX, 16'h1234));
      plan.push_back(step_row(16'h0000, gql_pkg::ACT_DOWN));
      plan.push_back(step_row(16'h0000, gql_pkg::ACT_DOWN));
      plan.push_back(step_row(16'h0000, gql_pkg::ACT_DOWN));
      plan.push_back(step_row(16'h0000, gql_pkg::ACT_RIGHT));
      plan.push_back(step_row(16'h0000, gql_pkg::ACT_RIGHT));
      plan.push_back(step_row(16'h0000, gql_pkg::ACT_RIGHT));
      plan.push_back(step_row(16'hFFFF, gql_pkg::ACT_UP));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            if (pending_results.size() != 0) wait_drained();
            write_reg(plan[i].addr, plan[i].wdata);
         end else begin
            send_item(plan[i].item, plan[i].typed, plan[i].want);
         end
      end

      // Random phases, each under its own training setup
      sent_items = 0;
      while (sent_items < TOTAL_ITEMS) begin
         wait_drained();
         steady = ($urandom_range(0, 3) == 0);
         pick_training_setup();
         phase_len = $urandom_range(60, 180);
         for (int n = 0; n < phase_len; n++) begin
            item.explore_draw = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 9) < 6)
               item.random_move = $urandom_range(0, 1) ? gql_pkg::ACT_RIGHT
                                                       : gql_pkg::ACT_DOWN;
            else
               item.random_move = 2'($urandom_range(0, 3));
            send_item(item, 1'b0, '0);
            if ($urandom_range(0, 199) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### filelist.f
rtl/core/gql_pkg.sv
rtl/core/gql_mulrnd.sv
rtl/core/gridworld_q_learning_step.sv
rtl/core/gql_check.sv
bench/gridworld_q_learning_step_tb.sv
